// File: src/sscl_pkg.sv
// Package for the serial sound command latch: item types, register
// indexes, reset values and widths. No dependencies.
package sscl_pkg;

   localparam int PortW  = 8;
   localparam int PitchW = 18;
   localparam int StepW  = 12;
   localparam int BitSelW = 3;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 18;
   localparam int CodeShift = 12;

   localparam logic [PortW-1:0] EDGE_MASK = 8'h9f;
   localparam logic [PitchW-1:0] PITCH_MAX = 18'h3ffff;

   localparam logic [CsrIndexW-1:0] CSR_FALL_STEP  = 3'd0;
   localparam logic [CsrIndexW-1:0] CSR_RISE_STEP  = 3'd1;
   localparam logic [CsrIndexW-1:0] CSR_FLOOR      = 3'd2;
   localparam logic [CsrIndexW-1:0] CSR_DATA_BIT   = 3'd3;
   localparam logic [CsrIndexW-1:0] CSR_CLOCK_BIT  = 3'd4;

   localparam logic [StepW-1:0]   FALL_STEP_RESET = 12'd300;
   localparam logic [StepW-1:0]   RISE_STEP_RESET = 12'd200;
   localparam logic [PitchW-1:0]  FLOOR_RESET     = 18'h10000;
   localparam logic [BitSelW-1:0] DATA_BIT_RESET  = 3'd7;
   localparam logic [BitSelW-1:0] CLOCK_BIT_RESET = 3'd4;

   localparam logic [PortW-1:0]  PORT_RESET  = 8'hff;
   localparam logic [PortW-1:0]  SHIFT_RESET = 8'hff;
   localparam logic [PitchW-1:0] PITCH_RESET = 18'h20000;

   localparam logic OP_PORT_WRITE = 1'b0;
   localparam logic OP_FRAME_TICK = 1'b1;

   typedef struct packed {
      logic             op;
      logic [PortW-1:0] port_data;
   } req_item_type;

   typedef struct packed {
      logic [PortW-1:0]  start_mask;
      logic [PortW-1:0]  stop_mask;
      logic [PitchW-1:0] drone_pitch;
      logic              pitch_updated;
      logic [PortW-1:0]  port_readback;
   } rsp_item_type;

   typedef struct packed {
      logic [StepW-1:0]  fall_step;
      logic [StepW-1:0]  rise_step;
      logic [PitchW-1:0] floor_value;
   } pitch_cfg_type;

endpackage

// File: src/sscl_pitch.sv
// Drone pitch glide: a fall step, then a rise step, toward the decoded target,
// each only when needed, saturating at both ends. Depends on sscl_pkg.
module sscl_pitch
   import sscl_pkg::*;
(
   input  pitch_cfg_type     cfg,
   input  logic [PitchW-1:0] pitch,
   input  logic [3:0]        code,
   output logic [PitchW-1:0] pitch_next
);

   logic [PitchW:0]   target;
   logic [PitchW-1:0] after_fall;
   logic [PitchW:0]   rise_sum;

   assign target = {1'b0, cfg.floor_value} + {3'b000, code, {CodeShift{1'b0}}};

   always_comb begin
      if ({1'b0, pitch} > target) begin
         if (pitch > {{(PitchW-StepW){1'b0}}, cfg.fall_step}) begin
            after_fall = pitch - {{(PitchW-StepW){1'b0}}, cfg.fall_step};
         end else begin
            after_fall = '0;
         end
      end else begin
         after_fall = pitch;
      end
   end

   assign rise_sum = {1'b0, after_fall} + {{(PitchW+1-StepW){1'b0}}, cfg.rise_step};

   always_comb begin
      if ({1'b0, after_fall} < target) begin
         pitch_next = rise_sum[PitchW] ? PITCH_MAX : rise_sum[PitchW-1:0];
      end else begin
         pitch_next = after_fall;
      end
   end

endmodule

// File: src/serial_sound_command_latch.sv
// Serial sound command latch: input register, one pass of edge, shift and
// pitch logic, result register; rsp_valid comes from the result register.
// Throughput: one item per cycle unless rsp_stall holds the result; the
// result register frees the input side.
// Reset (synchronous): port 0xff, shift and latch 0xff, pitch 0x20000, no
// frame pending, registers to their defaults, both stages empty.
module serial_sound_command_latch
   import sscl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_item_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_item_type         rsp_data,
   input  logic                 csr_write_enable,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_write_data
);

   pitch_cfg_type      pcfg_ff, pcfg_in;
   logic [BitSelW-1:0] data_bit_ff, data_bit_in;
   logic [BitSelW-1:0] clock_bit_ff, clock_bit_in;

   logic               in_valid_ff, in_valid_in;
   req_item_type       in_item_ff, in_item_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;

   logic [PortW-1:0]   prev_ff, prev_in;
   logic [PortW-1:0]   shift_ff, shift_in;
   logic [PortW-1:0]   latched_ff, latched_in;
   logic [PitchW-1:0]  pitch_ff, pitch_in;
   logic               frame_ff, frame_in;

   logic               advance;
   logic               accept;
   logic [PortW-1:0]   val;
   logic [PortW-1:0]   fell;
   logic [PortW-1:0]   shift_next;
   logic [PortW-1:0]   diff;
   logic [PortW-1:0]   start;
   logic [PortW-1:0]   stop;
   logic [3:0]         code;
   logic [PitchW-1:0]  pitch_step;
   logic               update;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // configuration
   always_comb begin
      pcfg_in      = pcfg_ff;
      data_bit_in  = data_bit_ff;
      clock_bit_in = clock_bit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FALL_STEP: pcfg_in.fall_step   = csr_write_data[StepW-1:0];
            CSR_RISE_STEP: pcfg_in.rise_step   = csr_write_data[StepW-1:0];
            CSR_FLOOR:     pcfg_in.floor_value = csr_write_data[PitchW-1:0];
            CSR_DATA_BIT:  data_bit_in         = csr_write_data[BitSelW-1:0];
            CSR_CLOCK_BIT: clock_bit_in        = csr_write_data[BitSelW-1:0];
            default: ;
         endcase
      end
   end

   // edge detect, shift and channel decode on the registered item
   assign val  = in_item_ff.port_data & EDGE_MASK;
   assign fell = ((prev_ff ^ in_item_ff.port_data) & EDGE_MASK) & ~val;

   assign shift_next = fell[clock_bit_ff] ? {shift_ff[PortW-2:0], val[data_bit_ff]} : shift_ff;
   assign diff       = shift_next ^ latched_ff;
   assign code       = {shift_next[6], shift_next[5], shift_next[6], shift_next[7]};
   assign update     = fell[0] && frame_ff;

   always_comb begin
      start = '0;
      stop  = '0;
      if (fell[0]) begin
         start[2] = diff[0] && !shift_next[0];
         start[5] = diff[1] && !shift_next[1];
         start[6] = diff[2] && shift_next[2];
         stop[6]  = diff[2] && !shift_next[2];
         stop[7]  = diff[3] && shift_next[3];
         start[7] = diff[3] && !shift_next[3];
         stop[4]  = diff[4] && shift_next[4];
         start[4] = diff[4] && !shift_next[4];
      end
      start[3] = fell[3];
      start[1] = fell[2];
      start[0] = fell[1];
   end

   sscl_pitch u_pitch (
      .cfg        (pcfg_ff),
      .pitch      (pitch_ff),
      .code       (code),
      .pitch_next (pitch_step)
   );

   always_comb begin
      prev_in     = prev_ff;
      shift_in    = shift_ff;
      latched_in  = latched_ff;
      pitch_in    = pitch_ff;
      frame_in    = frame_ff;
      out_item_in = out_item_ff;
      if (advance) begin
         if (in_item_ff.op == OP_FRAME_TICK) begin
            frame_in                  = 1'b1;
            out_item_in.start_mask    = '0;
            out_item_in.stop_mask     = '0;
            out_item_in.drone_pitch   = pitch_ff;
            out_item_in.pitch_updated = 1'b0;
            out_item_in.port_readback = prev_ff;
         end else begin
            prev_in  = in_item_ff.port_data;
            shift_in = shift_next;
            if (fell[0]) begin
               latched_in = shift_next;
            end
            if (update) begin
               pitch_in = pitch_step;
               frame_in = 1'b0;
            end
            out_item_in.start_mask    = start;
            out_item_in.stop_mask     = stop;
            out_item_in.drone_pitch   = update ? pitch_step : pitch_ff;
            out_item_in.pitch_updated = update;
            out_item_in.port_readback = in_item_ff.port_data;
         end
      end
   end

   always_comb begin
      in_item_in  = accept ? req_data : in_item_ff;
      in_valid_in = accept || (in_valid_ff && !advance);
      if (advance) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcfg_ff.fall_step   <= FALL_STEP_RESET;
         pcfg_ff.rise_step   <= RISE_STEP_RESET;
         pcfg_ff.floor_value <= FLOOR_RESET;
         data_bit_ff         <= DATA_BIT_RESET;
         clock_bit_ff        <= CLOCK_BIT_RESET;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         prev_ff             <= PORT_RESET;
         shift_ff            <= SHIFT_RESET;
         latched_ff          <= SHIFT_RESET;
         pitch_ff            <= PITCH_RESET;
         frame_ff            <= 1'b0;
      end else begin
         pcfg_ff      <= pcfg_in;
         data_bit_ff  <= data_bit_in;
         clock_bit_ff <= clock_bit_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         shift_ff     <= shift_in;
         latched_ff   <= latched_in;
         pitch_ff     <= pitch_in;
         frame_ff     <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

// File: verif/sscl_check_pkg.sv
// Scoreboard for the serial sound command latch: predicts the result of each
// accepted item from its own copy of the latch state and checks results in order.
// Depends on sscl_pkg.
package sscl_check_pkg;
   import sscl_pkg::*;

   class latch_scoreboard;
      logic [StepW-1:0]   fall_step;
      logic [StepW-1:0]   rise_step;
      logic [PitchW-1:0]  floor_value;
      logic [BitSelW-1:0] data_bit;
      logic [BitSelW-1:0] clock_bit;
      logic [PortW-1:0]   last_port;
      logic [PortW-1:0]   shift_reg;
      logic [PortW-1:0]   latched;
      logic [PitchW-1:0]  pitch;
      logic               frame_seen;
      rsp_item_type       expected_rsps[$];
      int                 failures;

      function new();
         fall_step   = FALL_STEP_RESET;
         rise_step   = RISE_STEP_RESET;
         floor_value = FLOOR_RESET;
         data_bit    = DATA_BIT_RESET;
         clock_bit   = CLOCK_BIT_RESET;
         last_port   = PORT_RESET;
         shift_reg   = SHIFT_RESET;
         latched     = SHIFT_RESET;
         pitch       = PITCH_RESET;
         frame_seen  = 1'b0;
         failures    = 0;
      endfunction

      function void write_reg(logic [CsrIndexW-1:0] index, logic [CsrDataW-1:0] value);
         case (index)
            CSR_FALL_STEP: fall_step   = value[StepW-1:0];
            CSR_RISE_STEP: rise_step   = value[StepW-1:0];
            CSR_FLOOR:     floor_value = value[PitchW-1:0];
            CSR_DATA_BIT:  data_bit    = value[BitSelW-1:0];
            CSR_CLOCK_BIT: clock_bit   = value[BitSelW-1:0];
            default: ;
         endcase
      endfunction

      function void note_item(req_item_type item);
         rsp_item_type      rsp;
         logic [PortW-1:0]  changed;
         logic [PortW-1:0]  level;
         logic [PortW-1:0]  diff;
         logic [3:0]        code;
         logic [PitchW+1:0] target;
         logic [PitchW:0]   raised;
         rsp = '0;
         if (item.op == OP_FRAME_TICK) begin
            frame_seen = 1'b1;
         end else begin
            changed = (last_port ^ item.port_data) & EDGE_MASK;
            level   = item.port_data & EDGE_MASK;
            if (changed[clock_bit] && !level[clock_bit]) begin
               shift_reg = {shift_reg[PortW-2:0], level[data_bit]};
            end
            if (changed[0] && !level[0]) begin
               diff = shift_reg ^ latched;
               if (diff[0] && !shift_reg[0]) rsp.start_mask[2] = 1'b1;
               if (diff[1] && !shift_reg[1]) rsp.start_mask[5] = 1'b1;
               if (diff[2]) begin
                  if (shift_reg[2]) rsp.start_mask[6] = 1'b1;
                  else rsp.stop_mask[6] = 1'b1;
               end
               if (diff[3]) begin
                  if (shift_reg[3]) rsp.stop_mask[7] = 1'b1;
                  else rsp.start_mask[7] = 1'b1;
               end
               if (diff[4]) begin
                  if (shift_reg[4]) rsp.stop_mask[4] = 1'b1;
                  else rsp.start_mask[4] = 1'b1;
               end
               code   = {shift_reg[6], shift_reg[5], shift_reg[6], shift_reg[7]};
               target = (PitchW+2)'(floor_value) + ((PitchW+2)'(code) << CodeShift);
               if (frame_seen) begin
                  // fall first, then rise from the new value
                  if ((PitchW+2)'(pitch) > target) begin
                     pitch = (pitch > fall_step) ? pitch - fall_step : '0;
                  end
                  if ((PitchW+2)'(pitch) < target) begin
                     raised = {1'b0, pitch} + rise_step;
                     pitch  = (raised > PITCH_MAX) ? PITCH_MAX : raised[PitchW-1:0];
                  end
                  rsp.pitch_updated = 1'b1;
                  frame_seen = 1'b0;
               end
               latched = shift_reg;
            end
            if (changed[3] && !level[3]) rsp.start_mask[3] = 1'b1;
            if (changed[2] && !level[2]) rsp.start_mask[1] = 1'b1;
            if (changed[1] && !level[1]) rsp.start_mask[0] = 1'b1;
            last_port = item.port_data;
         end
         rsp.drone_pitch   = pitch;
         rsp.port_readback = last_port;
         expected_rsps.push_back(rsp);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_rsps.size() == 0) begin
            $error("result with no item waiting: %h", got);
            failures++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.start_mask !== want.start_mask) begin
            $error("start_mask expected %h got %h", want.start_mask, got.start_mask);
            failures++;
         end
         if (got.stop_mask !== want.stop_mask) begin
            $error("stop_mask expected %h got %h", want.stop_mask, got.stop_mask);
            failures++;
         end
         if (got.drone_pitch !== want.drone_pitch) begin
            $error("drone_pitch expected %h got %h", want.drone_pitch, got.drone_pitch);
            failures++;
         end
         if (got.pitch_updated !== want.pitch_updated) begin
            $error("pitch_updated expected %b got %b", want.pitch_updated,
                   got.pitch_updated);
            failures++;
         end
         if (got.port_readback !== want.port_readback) begin
            $error("port_readback expected %h got %h", want.port_readback,
                   got.port_readback);
            failures++;
         end
      endfunction
   endclass

endpackage

// File: verif/testbench.sv
// Testbench for serial_sound_command_latch: directed items, then serial
// commands, latch bursts and noise under several register settings and idling
// and output-stall phases. Depends on sscl_pkg, sscl_check_pkg and the block.
module testbench;
   import sscl_pkg::*;
   import sscl_check_pkg::*;

   localparam int StallLimit  = 2000;
   localparam int RandomItems = 2000;
   localparam int PhaseCount  = 8;
   localparam int DrainCycles = 4;
   localparam logic [CsrIndexW-1:0] CSR_SPARE = 3'd7;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_item_type         req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_item_type         rsp_data;
   logic                 csr_write_enable = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_write_data = '0;

   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   quiet_cycles = 0;
   int                   items_sent = 0;
   logic [BitSelW-1:0]   data_sel = DATA_BIT_RESET;
   logic [BitSelW-1:0]   clock_sel = CLOCK_BIT_RESET;
   latch_scoreboard      board = new;

   serial_sound_command_latch i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) board.write_reg(csr_index, csr_write_data);
         if (req_valid && !req_stall) board.note_item(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
         $display("[serial_sound_command_latch] ERROR");
         $finish;
      end
   end

   task automatic send_item(input logic op, input logic [PortW-1:0] port_data);
      req_item_type item;
      item.op        = op;
      item.port_data = port_data;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // wait until every item has its result, then let the pipeline settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_rsps.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexW-1:0] index,
                            input logic [CsrDataW-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      if (index == CSR_DATA_BIT) data_sel = value[BitSelW-1:0];
      if (index == CSR_CLOCK_BIT) clock_sel = value[BitSelW-1:0];
      @(posedge clock);
   endtask

   // upper bits beyond each step and bit-select register's width carry junk
   task automatic configure(input logic [StepW-1:0] fall, input logic [StepW-1:0] rise,
                            input logic [PitchW-1:0] floor_value,
                            input logic [BitSelW-1:0] dsel,
                            input logic [BitSelW-1:0] csel);
      write_reg(CSR_FALL_STEP, {(CsrDataW-StepW)'($urandom), fall});
      write_reg(CSR_RISE_STEP, {(CsrDataW-StepW)'($urandom), rise});
      write_reg(CSR_FLOOR, floor_value);
      write_reg(CSR_DATA_BIT, {(CsrDataW-BitSelW)'($urandom), dsel});
      write_reg(CSR_CLOCK_BIT, {(CsrDataW-BitSelW)'($urandom), csel});
      write_reg(CSR_SPARE, CsrDataW'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // eight clocked bits, then a latch strobe on port bit 0
   task automatic send_command();
      logic [PortW-1:0] cmd;
      logic [PortW-1:0] base;
      logic [PortW-1:0] port;
      cmd  = PortW'($urandom);
      base = PortW'($urandom) | 8'h01;
      port = base;
      for (int i = PortW - 1; i >= 0; i--) begin
         if ($urandom_range(15) == 0) send_item(OP_FRAME_TICK, PortW'($urandom));
         if ($urandom_range(3) == 0) base = PortW'($urandom) | 8'h01;
         port = base;
         port[data_sel]  = cmd[i];
         port[clock_sel] = 1'b1;
         send_item(OP_PORT_WRITE, port);
         port[clock_sel] = 1'b0;
         send_item(OP_PORT_WRITE, port);
      end
      if ($urandom_range(3) != 0) send_item(OP_FRAME_TICK, PortW'($urandom));
      send_item(OP_PORT_WRITE, port | 8'h01);
      send_item(OP_PORT_WRITE, port & 8'hfe);
   endtask

   // repeated frame and latch pairs step the pitch toward its target
   task automatic send_latch_burst();
      logic [PortW-1:0] port;
      port = PortW'($urandom);
      repeat ($urandom_range(8, 2)) begin
         send_item(OP_FRAME_TICK, PortW'($urandom));
         send_item(OP_PORT_WRITE, port | 8'h01);
         send_item(OP_PORT_WRITE, port & 8'hfe);
      end
   endtask

   initial begin
      int pick;
      int phase_end;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_PORT_WRITE, 8'hff);
      send_item(OP_FRAME_TICK, 8'h00);
      send_item(OP_FRAME_TICK, 8'hff);
      send_item(OP_PORT_WRITE, 8'h00);
      send_item(OP_PORT_WRITE, 8'hff);
      send_item(OP_PORT_WRITE, 8'h60);
      send_item(OP_PORT_WRITE, 8'h9f);
      repeat (3) begin
         send_item(OP_PORT_WRITE, 8'h7f);
         send_item(OP_PORT_WRITE, 8'h6f);
      end
      send_item(OP_FRAME_TICK, 8'h55);
      send_item(OP_PORT_WRITE, 8'h6e);
      send_item(OP_PORT_WRITE, 8'h6f);
      drain();
      // clock and data on the masked bits
      configure(FALL_STEP_RESET, RISE_STEP_RESET, FLOOR_RESET, 3'd6, 3'd5);
      send_item(OP_PORT_WRITE, 8'hff);
      send_item(OP_PORT_WRITE, 8'hdf);
      send_item(OP_PORT_WRITE, 8'hde);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         drain();
         case (phase)
            0: configure(FALL_STEP_RESET, RISE_STEP_RESET, FLOOR_RESET,
                         DATA_BIT_RESET, CLOCK_BIT_RESET);
            1: configure(12'hfff, 12'hfff, 18'h3ffff, 3'd0, 3'd7);
            2: configure(12'hfff, 12'h000, 18'h00000, 3'd7, 3'd0);
            3: configure(12'h000, 12'h000, 18'h20000, 3'd5, 3'd6);
            4: configure(12'h001, 12'hfff, 18'h3ffff, BitSelW'($urandom), BitSelW'($urandom));
            default: configure(StepW'($urandom), StepW'($urandom), PitchW'($urandom),
                               BitSelW'($urandom), BitSelW'($urandom));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 62; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 62; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         phase_end = items_sent + RandomItems / PhaseCount;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               send_command();
            end else if (pick < 80) begin
               send_latch_burst();
            end else if (pick < 97) begin
               repeat ($urandom_range(6, 1)) begin
                  send_item(1'($urandom), PortW'($urandom));
               end
            end else begin
               drain();
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.expected_rsps.size() == 0)
         $display("[serial_sound_command_latch] OK");
      else
         $display("[serial_sound_command_latch] ERROR");
      $finish;
   end

endmodule
